@@ hdl/utf8d_pkg.sv @@
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; imported by utf8d_front, utf8d_queue, utf8d_back and the top level.
package utf8d_pkg;

    // Queue between the classifier and the sequence engine
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int CP_W    = 21;
    localparam int COUNT_W = 3;
    localparam int STAT_W  = 2;
    localparam int VAL_W   = 7;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_TRUNC   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CLS_ASCII,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4,
        CLS_CONT,
        CLS_BAD
    } t_class;

    // Which lead bytes restrict the range of the second byte
    typedef enum logic [2:0] {
        CHK_NONE,
        CHK_E0,
        CHK_ED,
        CHK_F0,
        CHK_F4
    } t_lead_chk;

    // One classified byte as it travels through the queue
    typedef struct packed {
        t_class             cls;
        t_lead_chk          chk;
        logic               ge_a0;
        logic               ge_90;
        logic [VAL_W-1:0]   value;
        logic               eob;
    } t_beat;

endpackage

@@ hdl/utf8d_front.sv @@
// Byte classifier: sorts each raw byte into lead/continuation/ASCII/invalid
// and precomputes the second-byte range flags. Depends on utf8d_pkg.
module utf8d_front (
    input  logic [7:0]     i_data_byte,
    input  logic           i_end_of_buffer,
    output utf8d_pkg::t_beat o_beat
);
    import utf8d_pkg::*;

    always_comb begin
        o_beat.cls   = CLS_BAD;
        o_beat.chk   = CHK_NONE;
        o_beat.value = '0;
        o_beat.eob   = i_end_of_buffer;
        o_beat.ge_a0 = (i_data_byte >= 8'hA0);
        o_beat.ge_90 = (i_data_byte >= 8'h90);
        case (i_data_byte) inside
            [8'h00:8'h7F]: begin
                o_beat.cls   = CLS_ASCII;
                o_beat.value = i_data_byte[6:0];
            end
            [8'h80:8'hBF]: begin
                o_beat.cls   = CLS_CONT;
                o_beat.value = {1'b0, i_data_byte[5:0]};
            end
            [8'hC2:8'hDF]: begin
                o_beat.cls   = CLS_LEAD2;
                o_beat.value = {2'b00, i_data_byte[4:0]};
            end
            [8'hE0:8'hEF]: begin
                o_beat.cls   = CLS_LEAD3;
                o_beat.value = {3'b000, i_data_byte[3:0]};
            end
            [8'hF0:8'hF4]: begin
                o_beat.cls   = CLS_LEAD4;
                o_beat.value = {4'b0000, i_data_byte[2:0]};
            end
            default: o_beat.cls = CLS_BAD;
        endcase
        case (i_data_byte)
            8'hE0:   o_beat.chk = CHK_E0;
            8'hED:   o_beat.chk = CHK_ED;
            8'hF0:   o_beat.chk = CHK_F0;
            8'hF4:   o_beat.chk = CHK_F4;
            default: o_beat.chk = CHK_NONE;
        endcase
    end

endmodule

@@ hdl/utf8d_queue.sv @@
// Short FIFO of classified beats between classifier and sequence engine.
// Depends on utf8d_pkg.
module utf8d_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  utf8d_pkg::t_beat i_beat,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output utf8d_pkg::t_beat o_beat
);
    import utf8d_pkg::*;

    t_beat                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_beat  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? QUEUE_PTR_W'((r_wr_ptr + 1'b1) % QUEUE_DEPTH) : r_wr_ptr;
        n_rd_ptr = i_pop  ? QUEUE_PTR_W'((r_rd_ptr + 1'b1) % QUEUE_DEPTH) : r_rd_ptr;
        n_count  = r_count + QUEUE_CNT_W'(i_push) - QUEUE_CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_beat;
        end
    end

endmodule

@@ hdl/utf8d_back.sv @@
// Sequence engine: assembles code points from classified beats, checks
// strict forms, and holds the result in an output register. Depends on utf8d_pkg.
module utf8d_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_beat_valid,
    input  utf8d_pkg::t_beat            i_beat,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [utf8d_pkg::CP_W-1:0]    o_code_point,
    output logic [utf8d_pkg::COUNT_W-1:0] o_byte_count,
    output logic [utf8d_pkg::STAT_W-1:0]  o_status,
    output logic                        o_last
);
    import utf8d_pkg::*;

    logic [1:0]         r_remaining, n_remaining;
    logic [CP_W-1:0]    r_value, n_value;
    t_lead_chk          r_chk, n_chk;
    logic [COUNT_W-1:0] r_len, n_len;
    logic               r_skip, n_skip;

    logic               r_out_valid, n_out_valid;
    logic [CP_W-1:0]    r_out_cp, n_out_cp;
    logic [COUNT_W-1:0] r_out_cnt, n_out_cnt;
    t_status            r_out_stat, n_out_stat;
    logic               r_out_last, n_out_last;

    logic               cont_ok;
    logic               second;
    logic [CP_W-1:0]    shifted;

    assign o_pop        = i_beat_valid && (!r_out_valid || i_ready);
    assign o_valid      = r_out_valid;
    assign o_code_point = r_out_cp;
    assign o_byte_count = r_out_cnt;
    assign o_status     = r_out_stat;
    assign o_last       = r_out_last;

    assign second  = ((r_len - COUNT_W'(r_remaining)) == COUNT_W'(1));
    assign shifted = {r_value[CP_W-7:0], i_beat.value[5:0]};

    always_comb begin
        cont_ok = (i_beat.cls == CLS_CONT);
        if (second) begin
            case (r_chk)
                CHK_E0:  if (!i_beat.ge_a0) cont_ok = 1'b0;
                CHK_ED:  if (i_beat.ge_a0)  cont_ok = 1'b0;
                CHK_F0:  if (!i_beat.ge_90) cont_ok = 1'b0;
                CHK_F4:  if (i_beat.ge_90)  cont_ok = 1'b0;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_remaining = r_remaining;
        n_value     = r_value;
        n_chk       = r_chk;
        n_len       = r_len;
        n_skip      = r_skip;
        n_out_valid = r_out_valid && !i_ready;
        n_out_cp    = r_out_cp;
        n_out_cnt   = r_out_cnt;
        n_out_stat  = r_out_stat;
        n_out_last  = r_out_last;

        if (o_pop) begin
            if (r_skip) begin
                if (i_beat.eob) begin
                    n_skip = 1'b0;
                end
            end else begin
                // default result is an error; ok and truncation paths overwrite it
                n_out_cp   = '0;
                n_out_cnt  = '0;
                n_out_last = i_beat.eob;
                n_out_stat = ST_INVALID;
                if (r_remaining == 2'd0) begin
                    case (i_beat.cls)
                        CLS_ASCII: begin
                            n_out_valid = 1'b1;
                            n_out_cp    = CP_W'(i_beat.value);
                            n_out_cnt   = COUNT_W'(1);
                            n_out_stat  = ST_OK;
                        end
                        CLS_LEAD2, CLS_LEAD3, CLS_LEAD4: begin
                            if (i_beat.eob) begin
                                n_out_valid = 1'b1;
                                n_out_stat  = ST_TRUNC;
                            end else begin
                                n_value = CP_W'(i_beat.value);
                                n_chk   = i_beat.chk;
                                case (i_beat.cls)
                                    CLS_LEAD2: begin
                                        n_len = COUNT_W'(2);
                                        n_remaining = 2'd1;
                                    end
                                    CLS_LEAD3: begin
                                        n_len = COUNT_W'(3);
                                        n_remaining = 2'd2;
                                    end
                                    default: begin
                                        n_len = COUNT_W'(4);
                                        n_remaining = 2'd3;
                                    end
                                endcase
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_skip      = !i_beat.eob;
                        end
                    endcase
                end else if (!cont_ok) begin
                    n_out_valid = 1'b1;
                    n_skip      = !i_beat.eob;
                    n_remaining = 2'd0;
                    n_value     = '0;
                    n_chk       = CHK_NONE;
                    n_len       = '0;
                end else if (r_remaining == 2'd1) begin
                    n_out_valid = 1'b1;
                    n_out_cp    = shifted;
                    n_out_cnt   = r_len;
                    n_out_stat  = ST_OK;
                    n_remaining = 2'd0;
                    n_value     = '0;
                    n_chk       = CHK_NONE;
                    n_len       = '0;
                end else if (i_beat.eob) begin
                    n_out_valid = 1'b1;
                    n_out_stat  = ST_TRUNC;
                    n_remaining = 2'd0;
                    n_value     = '0;
                    n_chk       = CHK_NONE;
                    n_len       = '0;
                end else begin
                    n_value     = shifted;
                    n_remaining = r_remaining - 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= '0;
            r_value     <= '0;
            r_chk       <= CHK_NONE;
            r_len       <= '0;
            r_skip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_remaining <= n_remaining;
            r_value     <= n_value;
            r_chk       <= n_chk;
            r_len       <= n_len;
            r_skip      <= n_skip;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_cp   <= n_out_cp;
        r_out_cnt  <= n_out_cnt;
        r_out_stat <= n_out_stat;
        r_out_last <= n_out_last;
    end

endmodule

@@ hdl/utf8_stream_decoder_unit.sv @@
// Strict UTF-8 stream decoder, one byte per beat. Each byte is classified on
// entry and written into a two-entry queue; the sequence engine drains the
// queue at one byte per clock while its output register is free or being read,
// and emits one result per completed code point (or one error per fault /
// truncated sequence, after which the rest of the buffer is dropped).
// Sustained rate is one byte per cycle whenever the result side keeps up. On
// the way from byte acceptance to result valid, the queue is written at the
// accepting edge and the engine output register is loaded after it.
// Depends on utf8d_pkg, utf8d_front, utf8d_queue, utf8d_back.
module utf8_stream_decoder_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_end_of_buffer,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [utf8d_pkg::CP_W-1:0]    o_code_point,
    output logic [utf8d_pkg::COUNT_W-1:0] o_byte_count,
    output logic [utf8d_pkg::STAT_W-1:0]  o_status,
    output logic                        o_last
);
    import utf8d_pkg::*;

    t_beat front_beat;
    t_beat queue_beat;
    logic  queue_full;
    logic  queue_empty;
    logic  pop;

    assign o_ready = !queue_full;

    utf8d_front u_front (
        .i_data_byte     (i_data_byte),
        .i_end_of_buffer (i_end_of_buffer),
        .o_beat          (front_beat)
    );

    utf8d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid && !queue_full),
        .i_beat  (front_beat),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_empty (queue_empty),
        .o_beat  (queue_beat)
    );

    utf8d_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_beat_valid (!queue_empty),
        .i_beat       (queue_beat),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_code_point (o_code_point),
        .o_byte_count (o_byte_count),
        .o_status     (o_status),
        .o_last       (o_last)
    );

endmodule
